[rtl/rtcdve_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// rtcdve_pkg: shared types and helpers for the calendar date encoder
// Holds the request and response records, the range limits, and small
// lookup functions for month lengths, the shifted-month day term and BCD.
// ============================================================================
package rtcdve_pkg;

    // One request: a calendar date and time plus a free weekday field.
    typedef struct packed {
        logic [13:0] year_full;
        logic [7:0]  month_num;
        logic [7:0]  day_of_month;
        logic [7:0]  hour_num;
        logic [7:0]  minute_num;
        logic [7:0]  second_num;
        logic [7:0]  weekday_num;
    } t_req;

    // One response: status, the clock chip register bytes and the epoch count.
    typedef struct packed {
        logic        status_code;
        logic [7:0]  bcd_second;
        logic [7:0]  bcd_minute;
        logic [7:0]  bcd_hour;
        logic [7:0]  bcd_day;
        logic [7:0]  bcd_month;
        logic [7:0]  bcd_year;
        logic [2:0]  bcd_weekday;
        logic [31:0] epoch_seconds;
    } t_rsp;

    localparam logic [13:0] YEAR_LOW     = 14'd2000;
    localparam logic [13:0] YEAR_HIGH    = 14'd2099;
    localparam logic [7:0]  HOUR_LIMIT   = 8'd24;
    localparam logic [7:0]  MINSEC_LIMIT = 8'd60;
    localparam logic [7:0]  HOUR24_FLAG  = 8'h80;
    localparam logic        STATUS_OK    = 1'b0;
    localparam logic        STATUS_BAD   = 1'b1;

    // Day offset that ties the shifted year 1999 origin to 1970-01-01. Within the
    // shifted years 1999..2099 the century terms y/100 and y/400 always
    // net out to -15, so only y/4 and 365*y vary with the year.
    localparam logic [15:0] DAY_BIAS     = 16'd10620;

    // Length of a month; zero for codes that are not months.
    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        case (mo) inside
            4'd2:                                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                  len = 5'd0;
        endcase
        return len;
    endfunction

    // floor(367 * m / 12) for the shifted month m (March is 1).
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] term;
        case (m)
            4'd1:    term = 9'd30;
            4'd2:    term = 9'd61;
            4'd3:    term = 9'd91;
            4'd4:    term = 9'd122;
            4'd5:    term = 9'd152;
            4'd6:    term = 9'd183;
            4'd7:    term = 9'd214;
            4'd8:    term = 9'd244;
            4'd9:    term = 9'd275;
            4'd10:   term = 9'd305;
            4'd11:   term = 9'd336;
            4'd12:   term = 9'd367;
            default: term = 9'd0;
        endcase
        return term;
    endfunction

    // Packed BCD of a value below 100. The tens digit comes from a
    // multiply by the reciprocal of ten, exact over this range.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {8'd0, v} * 15'd205;
        tens = prod[14:11];
        ones = v - 7'({tens, 3'd0} + {2'd0, tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

endpackage

[rtl/rtc_date_validate_encode.sv]
`timescale 1ns / 1ps
// ============================================================================
// rtc_date_validate_encode: calendar date check, BCD and epoch encoder
// Checks a calendar date and time, packs it into clock chip BCD register
// bytes and counts the seconds since 1970-01-01 00:00:00.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ----------------------
//  request   in         i_valid / o_stall    i_req  (t_req)
//  response  out        o_valid / i_stall    o_rsp  (t_rsp)
//
//  Every request yields exactly one response. One request can enter every
//  cycle while the response side is not stalled.
//  The five stages come from the range check, the day count, and the chain
//  of three constant multiplies (by 24, 60 and 60) that turn the day count
//  into seconds, one multiply per stage.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  A stall on the response side holds each full stage; empty stages still
//  fill, so bubbles are squeezed out before the input side is stalled.
//
// Stage 1 checks the ranges and forms the shifted year and month.
// Stage 2 forms the day count and the BCD bytes, zeroed for a bad request.
// Stages 3 to 5 scale days to hours, minutes and seconds.
module rtc_date_validate_encode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rtcdve_pkg::t_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output rtcdve_pkg::t_rsp  o_rsp
);
    import rtcdve_pkg::*;

    // Stage valid bits and the ready chain that runs back from the output.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // Stage 1 registers.
    logic       r_s1_ok;
    logic [6:0] r_s1_t;
    logic [8:0] r_s1_mterm;
    logic [6:0] r_s1_yoff;
    logic [3:0] r_s1_mo;
    logic [4:0] r_s1_dy;
    logic [4:0] r_s1_hr;
    logic [5:0] r_s1_mn;
    logic [5:0] r_s1_sc;
    logic [2:0] r_s1_wd;

    // Stage 2 to 5 registers.
    logic [15:0] r_s2_days;
    t_rsp        r_s2_rsp;
    t_rsp        r_s3_rsp;
    t_rsp        r_s4_rsp;
    t_rsp        r_s5_rsp;
    logic [20:0] r_s3_dh;
    logic [26:0] r_s4_dhm;

    // Next values.
    logic       n_s1_ok;
    logic [6:0] n_s1_t;
    logic [8:0] n_s1_mterm;
    logic [6:0] n_s1_yoff;
    logic [15:0] n_s2_days;
    t_rsp        n_s2_rsp;
    logic [20:0] n_s3_dh;
    logic [26:0] n_s4_dhm;
    t_rsp        n_s5_rsp;

    // Stage 1 working signals.
    logic        w_year_ok;
    logic        w_month_ok;
    logic        w_day_ok;
    logic        w_time_ok;
    logic        w_early;
    logic [13:0] w_yoff_full;
    logic [3:0]  w_mshift;

    assign w_rdy5  = !r_v5 || !i_stall;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r_v5;
    assign o_rsp   = r_s5_rsp;

    // Range checks. Within 2000..2099 the leap rule reduces to a multiple
    // of four, since 2000 is a multiple of 400. A month of zero has length
    // zero, so any day fails it.
    always_comb begin
        w_year_ok   = (i_req.year_full >= YEAR_LOW) && (i_req.year_full <= YEAR_HIGH);
        w_month_ok  = (i_req.month_num >= 8'd1) && (i_req.month_num <= 8'd12);
        w_day_ok    = (i_req.day_of_month != 8'd0) && w_month_ok &&
                      (i_req.day_of_month <=
                       {3'd0, month_len(i_req.month_num[3:0],
                                        i_req.year_full[1:0] == 2'd0)});
        w_time_ok   = (i_req.hour_num < HOUR_LIMIT) &&
                      (i_req.minute_num < MINSEC_LIMIT) &&
                      (i_req.second_num < MINSEC_LIMIT);
        n_s1_ok     = w_year_ok && w_month_ok && w_day_ok && w_time_ok;

        // January and February count as months 11 and 12 of the year before.
        w_early     = (i_req.month_num[3:0] <= 4'd2);
        w_yoff_full = i_req.year_full - YEAR_LOW;
        n_s1_yoff   = w_yoff_full[6:0];
        n_s1_t      = 7'(n_s1_yoff + 7'd1 - {6'd0, w_early});
        w_mshift    = w_early ? 4'(i_req.month_num[3:0] + 4'd10)
                              : 4'(i_req.month_num[3:0] - 4'd2);
        n_s1_mterm  = month_term(w_mshift);
    end

    // Day count from the shifted-year origin, and the register bytes.
    always_comb begin
        n_s2_days = DAY_BIAS + 16'(r_s1_t * 16'd365) + 16'((r_s1_t + 7'd3) >> 2)
                  + {7'd0, r_s1_mterm} + {11'd0, r_s1_dy};
        n_s2_rsp  = '0;
        if (r_s1_ok) begin
            n_s2_rsp.status_code = STATUS_OK;
            n_s2_rsp.bcd_second  = to_bcd({1'b0, r_s1_sc});
            n_s2_rsp.bcd_minute  = to_bcd({1'b0, r_s1_mn});
            n_s2_rsp.bcd_hour    = to_bcd({2'd0, r_s1_hr}) | HOUR24_FLAG;
            n_s2_rsp.bcd_day     = to_bcd({2'd0, r_s1_dy});
            n_s2_rsp.bcd_month   = to_bcd({3'd0, r_s1_mo});
            n_s2_rsp.bcd_year    = to_bcd(r_s1_yoff);
            n_s2_rsp.bcd_weekday = r_s1_wd;
        end else begin
            n_s2_rsp.status_code = STATUS_BAD;
        end
    end

    // Hours, minutes and seconds ride along to be added at their stage.
    logic [4:0] r_s2_hr;
    logic [5:0] r_s2_mn, r_s3_mn;
    logic [5:0] r_s2_sc, r_s3_sc, r_s4_sc;

    // Scale to seconds, one constant multiply per stage.
    always_comb begin
        n_s3_dh  = 21'({5'd0, r_s2_days} * 21'd24);
        n_s4_dhm = 27'({6'd0, r_s3_dh} * 27'd60);
        n_s5_rsp = r_s4_rsp;
        n_s5_rsp.epoch_seconds = r_s4_rsp.status_code ? 32'd0
                               : 32'({5'd0, r_s4_dhm} * 32'd60) + {26'd0, r_s4_sc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_ok    <= n_s1_ok;
            r_s1_t     <= n_s1_t;
            r_s1_mterm <= n_s1_mterm;
            r_s1_yoff  <= n_s1_yoff;
            r_s1_mo    <= i_req.month_num[3:0];
            r_s1_dy    <= i_req.day_of_month[4:0];
            r_s1_hr    <= i_req.hour_num[4:0];
            r_s1_mn    <= i_req.minute_num[5:0];
            r_s1_sc    <= i_req.second_num[5:0];
            r_s1_wd    <= i_req.weekday_num[2:0];
        end
        if (w_rdy2 && r_v1) begin
            r_s2_days <= n_s2_days;
            r_s2_rsp  <= n_s2_rsp;
            r_s2_hr   <= r_s1_hr;
            r_s2_mn   <= r_s1_mn;
            r_s2_sc   <= r_s1_sc;
        end
        if (w_rdy3 && r_v2) begin
            r_s3_dh  <= n_s3_dh + {16'd0, r_s2_hr};
            r_s3_rsp <= r_s2_rsp;
            r_s3_mn  <= r_s2_mn;
            r_s3_sc  <= r_s2_sc;
        end
        if (w_rdy4 && r_v3) begin
            r_s4_dhm <= n_s4_dhm + {21'd0, r_s3_mn};
            r_s4_rsp <= r_s3_rsp;
            r_s4_sc  <= r_s3_sc;
        end
        if (w_rdy5 && r_v4) begin
            r_s5_rsp <= n_s5_rsp;
        end
    end

`ifndef SYNTHESIS
    // A rejected response carries nothing but its status.
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status_code |->
            o_rsp.epoch_seconds == 32'd0 && o_rsp.bcd_hour == 8'd0 &&
            o_rsp.bcd_year == 8'd0 && o_rsp.bcd_weekday == 3'd0)
        else $error("rejected response carries nonzero fields");

    // An accepted response has the 24-hour flag and a time in 2000..2099.
    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.status_code |->
            o_rsp.bcd_hour[7] && o_rsp.epoch_seconds >= 32'd946684800 &&
            o_rsp.epoch_seconds <= 32'd4102444799)
        else $error("accepted response out of range");

    // A request taken at the input fills the first stage.
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted request lost at stage one");

    // The input side is only stalled when every stage holds a request.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall)
        else $error("input stalled with a free stage");
`endif

endmodule
